### src/ffd_pkg.sv
// Shared types, constants and helper functions for the form field extractor.
`default_nettype none
package ffd_pkg;

  localparam int MAX_KEY_BYTES    = 16;
  localparam int VALUE_COUNT_BITS = 12;
  localparam int KEY_CNT_BITS     = $clog2(MAX_KEY_BYTES + 1);
  localparam int KEY_BITS         = 8 * MAX_KEY_BYTES;
  localparam int QUEUE_DEPTH      = 4;
  localparam int QUEUE_PTR_BITS   = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_BITS   = $clog2(QUEUE_DEPTH + 1);
  localparam int MAX_RESULTS      = 3;

  localparam logic [1:0] REG_KEY_LOW  = 2'd0;
  localparam logic [1:0] REG_KEY_HIGH = 2'd1;
  localparam logic [1:0] REG_KEY_LEN  = 2'd2;
  localparam logic [1:0] REG_MAX_LEN  = 2'd3;

  localparam logic [1:0] PH_MATCH = 2'd0;
  localparam logic [1:0] PH_SKIP  = 2'd1;
  localparam logic [1:0] PH_VALUE = 2'd2;
  localparam logic [1:0] PH_DONE  = 2'd3;

  localparam logic [1:0] ESC_NONE  = 2'd0;
  localparam logic [1:0] ESC_PCT   = 2'd1;
  localparam logic [1:0] ESC_DIGIT = 2'd2;

  localparam logic [7:0] CH_AMP     = 8'h26;
  localparam logic [7:0] CH_EQ      = 8'h3D;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_PCT     = 8'h25;
  localparam logic [7:0] CH_SPACE   = 8'h20;

  typedef struct packed {
    logic [1:0]                   cnt;
    logic [MAX_RESULTS-1:0][7:0]  bytes;
    logic                         bare;
    logic                         done;
    logic                         found;
  } entry_t;

  function automatic logic is_hex(input logic [7:0] c);
    is_hex = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
             (c >= 8'h41 && c <= 8'h46);
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [7:0] v;
    v = 8'h00;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = c - 8'h30;
    end else if (c >= 8'h61 && c <= 8'h66) begin
      v = c - 8'h57;
    end else if (c >= 8'h41 && c <= 8'h46) begin
      v = c - 8'h37;
    end
    hex_val = v[3:0];
  endfunction

endpackage
`default_nettype wire

### src/form_field_extract_decode_top.sv
// Top level of the form field extractor with percent decoding.
// A byte's result words pass through a queue entry and the serializer's current-entry register.
// Throughput: one byte accepted per cycle; zero to three words per byte, one per tready cycle.
// A four-entry queue between decoder and serializer absorbs bursts; input stalls only when full.
// Reset (rst, synchronous) clears decoder state, queue and output; config returns to defaults.
`default_nettype none
module form_field_extract_decode_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [63:0] cfg_data,
  input  wire logic        s_axis_tvalid,
  output      logic        s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] body_byte
  input  wire logic        s_axis_tlast,
  output      logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output      logic [7:0]  m_axis_tdata,   // [7:0] value_byte
  output      logic [1:0]  m_axis_tuser,   // [0] byte_valid, [1] key_found
  output      logic        m_axis_tlast
);

  logic             push, pop, q_full, q_empty;
  ffd_pkg::entry_t  push_entry, q_head;
  logic             byte_valid, key_found;

  ffd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_byte    (s_axis_tdata),
    .in_last    (s_axis_tlast),
    .q_full     (q_full),
    .push       (push),
    .push_entry (push_entry)
  );

  ffd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (pop),
    .empty      (q_empty),
    .head       (q_head)
  );

  ffd_back u_back (
    .clk            (clk),
    .rst            (rst),
    .q_empty        (q_empty),
    .q_head         (q_head),
    .pop            (pop),
    .out_valid      (m_axis_tvalid),
    .out_ready      (m_axis_tready),
    .out_byte       (m_axis_tdata),
    .out_byte_valid (byte_valid),
    .out_done       (m_axis_tlast),
    .out_found      (key_found)
  );

  assign m_axis_tuser = {key_found, byte_valid};

endmodule
`default_nettype wire

### src/ffd_front.sv
// Front end: key matching, value tracking and percent decoding into result entries.
`default_nettype none
module ffd_front (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_we,
  input  wire logic [1:0]           cfg_index,
  input  wire logic [63:0]          cfg_data,
  input  wire logic                 in_valid,
  output      logic                 in_ready,
  input  wire logic [7:0]           in_byte,
  input  wire logic                 in_last,
  input  wire logic                 q_full,
  output      logic                 push,
  output      ffd_pkg::entry_t      push_entry
);

  logic [ffd_pkg::KEY_BITS-1:0]           key;
  logic [ffd_pkg::KEY_CNT_BITS-1:0]       key_length;
  logic [ffd_pkg::VALUE_COUNT_BITS-1:0]   max_value_len;

  logic [1:0]                             phase, phase_next;
  logic [ffd_pkg::KEY_CNT_BITS-1:0]       kmc, kmc_next;
  logic [ffd_pkg::VALUE_COUNT_BITS-1:0]   rvc, rvc_next;
  logic [1:0]                             esc, esc_next;
  logic [7:0]                             first, first_next;

  logic [ffd_pkg::KEY_CNT_BITS-1:0]       klen;
  logic [7:0]                             key_byte;
  logic                                   accept;

  logic [3:0][7:0]                        ob;
  logic [1:0]                             oc;
  logic                                   fin, fnd;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign klen     = (key_length > ffd_pkg::KEY_CNT_BITS'(ffd_pkg::MAX_KEY_BYTES)) ?
                    ffd_pkg::KEY_CNT_BITS'(ffd_pkg::MAX_KEY_BYTES) : key_length;
  assign key_byte = key[8*kmc[ffd_pkg::KEY_CNT_BITS-2:0] +: 8];

  always_ff @(posedge clk) begin
    if (rst) begin
      key           <= '0;
      key_length    <= ffd_pkg::KEY_CNT_BITS'(1);
      max_value_len <= ffd_pkg::VALUE_COUNT_BITS'(255);
    end else if (cfg_we) begin
      case (cfg_index)
        ffd_pkg::REG_KEY_LOW:  key[63:0]     <= cfg_data;
        ffd_pkg::REG_KEY_HIGH: key[127:64]   <= cfg_data;
        ffd_pkg::REG_KEY_LEN:  key_length    <= cfg_data[ffd_pkg::KEY_CNT_BITS-1:0];
        ffd_pkg::REG_MAX_LEN:  max_value_len <= cfg_data[ffd_pkg::VALUE_COUNT_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    logic [ffd_pkg::VALUE_COUNT_BITS-1:0] rvc_inc;
    logic                                 hx;
    logic                                 taken;
    phase_next = phase;
    kmc_next   = kmc;
    rvc_next   = rvc;
    esc_next   = esc;
    first_next = first;
    ob         = '0;
    oc         = 2'd0;
    fin        = 1'b0;
    fnd        = 1'b0;
    rvc_inc    = rvc + 1'b1;
    hx         = ffd_pkg::is_hex(in_byte);
    taken      = 1'b0;
    case (phase)
      ffd_pkg::PH_MATCH: begin
        if (in_byte == ffd_pkg::CH_AMP) begin
          kmc_next = '0;
        end else if (kmc < klen) begin
          if (in_byte == key_byte) begin
            kmc_next = kmc + 1'b1;
          end else begin
            phase_next = ffd_pkg::PH_SKIP;
          end
        end else if (in_byte == ffd_pkg::CH_EQ) begin
          phase_next = ffd_pkg::PH_VALUE;
          rvc_next   = '0;
          esc_next   = ffd_pkg::ESC_NONE;
          if (max_value_len == '0 || in_last) begin
            fin        = 1'b1;
            fnd        = 1'b1;
            phase_next = ffd_pkg::PH_DONE;
          end
        end else begin
          phase_next = ffd_pkg::PH_SKIP;
        end
        if (in_last && phase_next != ffd_pkg::PH_DONE) begin
          fin = 1'b1;
          fnd = 1'b0;
        end
      end
      ffd_pkg::PH_SKIP: begin
        if (in_byte == ffd_pkg::CH_AMP) begin
          phase_next = ffd_pkg::PH_MATCH;
          kmc_next   = '0;
        end
        if (in_last) begin
          fin = 1'b1;
        end
      end
      ffd_pkg::PH_VALUE: begin
        if (in_byte != ffd_pkg::CH_AMP) begin
          rvc_next = rvc_inc;
          if (esc_next == ffd_pkg::ESC_PCT) begin
            if (hx) begin
              first_next = in_byte;
              esc_next   = ffd_pkg::ESC_DIGIT;
              taken      = 1'b1;
            end else begin
              ob[oc] = ffd_pkg::CH_PCT;
              oc     = oc + 1'b1;
              esc_next = ffd_pkg::ESC_NONE;
            end
          end else if (esc_next == ffd_pkg::ESC_DIGIT) begin
            if (hx) begin
              ob[oc] = {ffd_pkg::hex_val(first), ffd_pkg::hex_val(in_byte)};
              oc     = oc + 1'b1;
              taken  = 1'b1;
            end else begin
              ob[oc] = ffd_pkg::CH_PCT;
              oc     = oc + 1'b1;
              ob[oc] = first;
              oc     = oc + 1'b1;
            end
            esc_next = ffd_pkg::ESC_NONE;
          end
          if (!taken) begin
            if (in_byte == ffd_pkg::CH_PLUS) begin
              ob[oc] = ffd_pkg::CH_SPACE;
              oc     = oc + 1'b1;
            end else if (in_byte == ffd_pkg::CH_PCT) begin
              esc_next = ffd_pkg::ESC_PCT;
            end else begin
              ob[oc] = in_byte;
              oc     = oc + 1'b1;
            end
          end
        end
        if (in_byte == ffd_pkg::CH_AMP || rvc_inc >= max_value_len || in_last) begin
          if (esc_next == ffd_pkg::ESC_PCT) begin
            ob[oc] = ffd_pkg::CH_PCT;
            oc     = oc + 1'b1;
          end else if (esc_next == ffd_pkg::ESC_DIGIT) begin
            ob[oc] = ffd_pkg::CH_PCT;
            oc     = oc + 1'b1;
            ob[oc] = first_next;
            oc     = oc + 1'b1;
          end
          esc_next   = ffd_pkg::ESC_NONE;
          fin        = 1'b1;
          fnd        = 1'b1;
          phase_next = ffd_pkg::PH_DONE;
        end
      end
      default: begin
        phase_next = ffd_pkg::PH_DONE;
      end
    endcase
    if (in_last) begin
      phase_next = ffd_pkg::PH_MATCH;
      kmc_next   = '0;
      rvc_next   = '0;
      esc_next   = ffd_pkg::ESC_NONE;
      first_next = 8'h00;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= ffd_pkg::PH_MATCH;
      kmc   <= '0;
      rvc   <= '0;
      esc   <= ffd_pkg::ESC_NONE;
      first <= 8'h00;
    end else if (accept) begin
      phase <= phase_next;
      kmc   <= kmc_next;
      rvc   <= rvc_next;
      esc   <= esc_next;
      first <= first_next;
    end
  end

  assign push                = accept && (oc != 2'd0 || fin);
  assign push_entry.cnt      = (oc == 2'd0) ? 2'd1 : oc;
  assign push_entry.bytes    = {ob[2], ob[1], ob[0]};
  assign push_entry.bare     = (oc == 2'd0);
  assign push_entry.done     = fin;
  assign push_entry.found    = fnd;

endmodule
`default_nettype wire

### src/ffd_queue.sv
// Short entry queue between the decoding front end and the output serializer.
`default_nettype none
module ffd_queue (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire ffd_pkg::entry_t  push_entry,
  output      logic             full,
  input  wire logic             pop,
  output      logic             empty,
  output      ffd_pkg::entry_t  head
);

  ffd_pkg::entry_t                     mem [ffd_pkg::QUEUE_DEPTH];
  logic [ffd_pkg::QUEUE_PTR_BITS-1:0]  wptr, rptr;
  logic [ffd_pkg::QUEUE_CNT_BITS-1:0]  count;

  assign full  = (count == ffd_pkg::QUEUE_CNT_BITS'(ffd_pkg::QUEUE_DEPTH));
  assign empty = (count == '0);
  assign head  = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + 1'b1;
      end
      if (pop) begin
        rptr <= rptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

### src/ffd_back.sv
// Back end: serializes queued entries into output words, one result per word.
`default_nettype none
module ffd_back (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             q_empty,
  input  wire ffd_pkg::entry_t  q_head,
  output      logic             pop,
  output      logic             out_valid,
  input  wire logic             out_ready,
  output      logic [7:0]       out_byte,
  output      logic             out_byte_valid,
  output      logic             out_done,
  output      logic             out_found
);

  ffd_pkg::entry_t  cur;
  logic             loaded;
  logic [1:0]       idx;
  logic             last_beat;
  logic             take;
  logic             advance;

  assign last_beat = (idx == cur.cnt - 2'd1);
  assign take      = loaded && out_ready;
  assign advance   = !loaded || (take && last_beat);
  assign pop       = advance && !q_empty;

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= q_head;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      loaded <= 1'b0;
      idx    <= 2'd0;
    end else if (advance) begin
      loaded <= !q_empty;
      idx    <= 2'd0;
    end else if (take) begin
      idx <= idx + 1'b1;
    end
  end

  always_comb begin
    case (idx)
      2'd0:    out_byte = cur.bytes[0];
      2'd1:    out_byte = cur.bytes[1];
      2'd2:    out_byte = cur.bytes[2];
      default: out_byte = 8'h00;
    endcase
  end

  assign out_valid      = loaded;
  assign out_byte_valid = !(cur.bare && last_beat);
  assign out_done       = cur.done && last_beat;
  assign out_found      = cur.found && cur.done && last_beat;

endmodule
`default_nettype wire

### src/ffd_checker.sv
// Port-level checker for the form field extractor, bound to the top level.
`default_nettype none
module ffd_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       m_axis_tvalid,
  input wire logic       m_axis_tready,
  input wire logic [7:0] m_axis_tdata,
  input wire logic [1:0] m_axis_tuser,
  input wire logic       m_axis_tlast
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) &&
      $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("output word changed while stalled");

  a_bare_is_last: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tlast && m_axis_tdata == 8'h00)
    else $error("bare marker without end of search");

  a_found_on_last: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tlast)
    else $error("key_found outside the final word");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("output valid right after reset");

endmodule

bind form_field_extract_decode_top ffd_checker u_ffd_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);
`default_nettype wire

### bench/form_field_extract_decode_checker.sv
// Checker for the form field extractor: predicts the decoded value words and compares them.
`timescale 1ns / 100ps
module form_field_extract_decode_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] body_byte
  input  logic        s_axis_tlast,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [7:0]  m_axis_tdata,   // [7:0] value_byte
  input  logic [1:0]  m_axis_tuser,   // [0] byte_valid, [1] key_found
  input  logic        m_axis_tlast,
  output int          outstanding,
  output int          mismatches,
  output int          bodies_seen,
  output int          words_checked
);
  import ffd_pkg::*;

  typedef struct packed {
    logic [7:0] value;
    logic       byte_valid;
    logic       value_done;
    logic       key_found;
  } value_word_t;

  value_word_t pending_value_words [$];
  value_word_t step_words [MAX_RESULTS];
  int          step_count;

  logic [63:0] key_low, key_high;
  logic [4:0]  key_len;
  logic [11:0] value_limit;

  logic [1:0]  phase;
  logic [4:0]  matched;
  logic [11:0] raw_count;
  logic [1:0]  esc;
  logic [7:0]  held_digit;

  value_word_t got, want;

  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [7:0] d;
    d = 8'h00;
    if (c >= "0" && c <= "9") d = 8'h10 | (c - "0");
    else if (c >= "a" && c <= "f") d = 8'h10 | (c - "a" + 8'd10);
    else if (c >= "A" && c <= "F") d = 8'h10 | (c - "A" + 8'd10);
    return d[4:0];
  endfunction

  function automatic logic [7:0] key_at(input int i);
    if (i < 8) return 8'(key_low >> (8 * i));
    return 8'(key_high >> (8 * (i - 8)));
  endfunction

  function automatic void clear_search();
    phase      = PH_MATCH;
    matched    = '0;
    raw_count  = '0;
    esc        = ESC_NONE;
    held_digit = '0;
  endfunction

  function automatic void put_byte(input logic [7:0] b);
    step_words[step_count] = '{b, 1'b1, 1'b0, 1'b0};
    step_count++;
  endfunction

  function automatic void close_search(input logic found);
    if (step_count == 0) begin
      step_words[0] = '{8'h00, 1'b0, 1'b1, found};
      step_count = 1;
    end else begin
      step_words[step_count-1].value_done = 1'b1;
      step_words[step_count-1].key_found  = found;
    end
  endfunction

  function automatic void flush_escape();
    if (esc == ESC_PCT) begin
      put_byte(CH_PCT);
    end else if (esc == ESC_DIGIT) begin
      put_byte(CH_PCT);
      put_byte(held_digit);
    end
    esc = ESC_NONE;
  endfunction

  function automatic void decode_value_byte(input logic [7:0] b);
    logic [4:0] h, hi_nibble;
    h = hex_digit(b);
    if (esc == ESC_PCT) begin
      if (h[4]) begin
        held_digit = b;
        esc = ESC_DIGIT;
        return;
      end
      put_byte(CH_PCT);
      esc = ESC_NONE;
    end else if (esc == ESC_DIGIT) begin
      if (h[4]) begin
        hi_nibble = hex_digit(held_digit);
        put_byte({hi_nibble[3:0], h[3:0]});
        esc = ESC_NONE;
        return;
      end
      put_byte(CH_PCT);
      put_byte(held_digit);
      esc = ESC_NONE;
    end
    if (b == CH_PLUS) put_byte(CH_SPACE);
    else if (b == CH_PCT) esc = ESC_PCT;
    else put_byte(b);
  endfunction

  function automatic void predict_value_words(input logic [7:0] b, input logic last);
    int klen;
    klen = (key_len > MAX_KEY_BYTES) ? MAX_KEY_BYTES : int'(key_len);
    step_count = 0;
    case (phase)
      PH_MATCH: begin
        if (b == CH_AMP) begin
          matched = '0;
        end else if (matched < klen) begin
          if (b == key_at(matched)) matched = matched + 5'd1;
          else phase = PH_SKIP;
        end else if (b == CH_EQ) begin
          phase = PH_VALUE;
          raw_count = '0;
          esc = ESC_NONE;
          if (value_limit == 0 || last) begin
            close_search(1'b1);
            phase = PH_DONE;
          end
        end else begin
          phase = PH_SKIP;
        end
        if (last && phase != PH_DONE) close_search(1'b0);
      end
      PH_SKIP: begin
        if (b == CH_AMP) begin
          phase = PH_MATCH;
          matched = '0;
        end
        if (last) close_search(1'b0);
      end
      PH_VALUE: begin
        if (b == CH_AMP) begin
          flush_escape();
          close_search(1'b1);
          phase = PH_DONE;
        end else begin
          raw_count = raw_count + 12'd1;
          decode_value_byte(b);
          if (raw_count >= value_limit || last) begin
            flush_escape();
            close_search(1'b1);
            phase = PH_DONE;
          end
        end
      end
      default: ;
    endcase
    if (last) clear_search();
    for (int i = 0; i < step_count; i++) pending_value_words.push_back(step_words[i]);
  endfunction

  task automatic report_mismatch(input string what, input value_word_t g, input value_word_t w);
    if (mismatches < 40)
      $display("[%0t] %s: got byte %02h valid %0b done %0b found %0b, want %02h %0b %0b %0b",
               $time, what, g.value, g.byte_valid, g.value_done, g.key_found,
               w.value, w.byte_valid, w.value_done, w.key_found);
    mismatches++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      key_low     = '0;
      key_high    = '0;
      key_len     = 5'd1;
      value_limit = 12'd255;
      clear_search();
      pending_value_words.delete();
      mismatches    = 0;
      bodies_seen   = 0;
      words_checked = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_KEY_LOW:  key_low     = cfg_data;
          REG_KEY_HIGH: key_high    = cfg_data;
          REG_KEY_LEN:  key_len     = cfg_data[4:0];
          REG_MAX_LEN:  value_limit = cfg_data[11:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        predict_value_words(s_axis_tdata, s_axis_tlast);
        if (s_axis_tlast) bodies_seen++;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = '{m_axis_tdata, m_axis_tuser[0], m_axis_tlast, m_axis_tuser[1]};
        words_checked++;
        if (pending_value_words.size() == 0) begin
          report_mismatch("unexpected value word", got, '0);
        end else begin
          want = pending_value_words.pop_front();
          if (got.value !== want.value || got.byte_valid !== want.byte_valid ||
              got.value_done !== want.value_done || got.key_found !== want.key_found)
            report_mismatch("value word differs", got, want);
        end
      end
    end
    outstanding <= pending_value_words.size();
  end

endmodule

### bench/form_field_extract_decode_top_tb.sv
// Testbench top for the form field extractor: stimulus, flow control and the verdict.
`timescale 1ns / 100ps
module form_field_extract_decode_top_tb;
  import ffd_pkg::*;

  localparam int RUN_LIMIT   = 200000;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASE_ITEMS = 70;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = REG_KEY_LOW;
  logic [63:0] cfg_data = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;   // [7:0] body_byte
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;        // [7:0] value_byte
  logic [1:0]  m_axis_tuser;        // [0] byte_valid, [1] key_found
  logic        m_axis_tlast;

  int outstanding, mismatches, bodies_seen, words_checked;

  logic       hold_start = 1'b0;
  int         hold_left = 0;
  int         send_idle_pct = 0;
  int         recv_stall_pct = 0;
  int         cycle_count = 0;
  int         bytes_sent = 0;
  int         settings_used = 1;
  int         phase_items;
  int         key_len_gen = 1;
  logic [7:0] key_text [MAX_KEY_BYTES];
  logic [7:0] form_body [$];

  string ALNUM = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789";
  string HEXCH = "0123456789abcdefABCDEF";

  form_field_extract_decode_top u_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  form_field_extract_decode_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .outstanding   (outstanding),
    .mismatches    (mismatches),
    .bodies_seen   (bodies_seen),
    .words_checked (words_checked)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
      hold_left <= 0;
    end else if (hold_start) begin
      m_axis_tready <= 1'b0;
      hold_left <= HOLD_CYCLES - 1;
    end else if (hold_left != 0) begin
      m_axis_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= RUN_LIMIT) begin
      $display("form_field_extract_decode_top: mismatch");
      $finish;
    end
  end

  function automatic logic [7:0] alnum_char();
    return ALNUM[$urandom_range(ALNUM.len() - 1)];
  endfunction

  function automatic logic [7:0] hex_char();
    return HEXCH[$urandom_range(HEXCH.len() - 1)];
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= last;
    do @(posedge clk); while (!s_axis_tready);
    bytes_sent++;
  endtask

  task automatic send_body();
    for (int i = 0; i < form_body.size(); i++) send_byte(form_body[i], i == form_body.size() - 1);
    form_body.delete();
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) form_body.push_back(s[i]);
    send_body();
  endtask

  // drop valid, wait for every expected word, then let the pipeline go quiet
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic configure(input logic [4:0] len_field, input logic [11:0] limit);
    logic [63:0] low, high;
    for (int i = 0; i < 8; i++) begin
      low[8*i +: 8]  = key_text[i];
      high[8*i +: 8] = key_text[i+8];
    end
    cfg_we <= 1'b1;
    cfg_index <= REG_KEY_LOW;
    cfg_data <= low;
    @(posedge clk);
    cfg_index <= REG_KEY_HIGH;
    cfg_data <= high;
    @(posedge clk);
    cfg_index <= REG_KEY_LEN;
    cfg_data <= 64'(len_field);
    @(posedge clk);
    cfg_index <= REG_MAX_LEN;
    cfg_data <= 64'(limit);
    @(posedge clk);
    cfg_we <= 1'b0;
    key_len_gen = (len_field > MAX_KEY_BYTES) ? MAX_KEY_BYTES : int'(len_field);
    settings_used++;
  endtask

  task automatic push_value_char();
    case ($urandom_range(9))
      0: form_body.push_back(CH_PLUS);
      1: begin
        form_body.push_back(CH_PCT);
        form_body.push_back(hex_char());
        form_body.push_back(hex_char());
      end
      2: form_body.push_back(CH_PCT);
      3: form_body.push_back(hex_char());
      4: form_body.push_back(8'($urandom_range(255)));
      5: form_body.push_back(CH_EQ);
      default: form_body.push_back(alnum_char());
    endcase
  endtask

  // mostly well-formed fields around the key, some near misses and some noise bodies
  task automatic build_form_body();
    int n_fields, pick, n;
    if ($urandom_range(9) == 0) begin
      n = $urandom_range(1, 8);
      repeat (n) form_body.push_back(8'($urandom_range(255)));
      return;
    end
    n_fields = $urandom_range(1, 4);
    for (int f = 0; f < n_fields; f++) begin
      if (f != 0) form_body.push_back(CH_AMP);
      pick = $urandom_range(9);
      n = (pick < 5) ? key_len_gen : $urandom_range(0, key_len_gen);
      for (int i = 0; i < n; i++) form_body.push_back(key_text[i]);
      if (pick >= 5 && pick < 8) form_body.push_back(alnum_char());
      else if (pick >= 8) form_body.push_back(8'($urandom_range(255)));
      if ($urandom_range(9) != 0) form_body.push_back(CH_EQ);
      n = $urandom_range(0, 10);
      repeat (n) push_value_char();
    end
  endtask

  initial begin
    for (int i = 0; i < MAX_KEY_BYTES; i++) key_text[i] = 8'h00;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // default key is a single zero byte
    form_body = {8'h00, CH_EQ, 8'hFF};
    send_body();
    settle();

    key_text[0] = "k";
    configure(5'd1, 12'd255);
    push_text("&k=%00+%4");
    push_text("x&k=%zA%4g&q");
    settle();
    configure(5'd0, 12'd255);
    push_text("=v");
    push_text("&");
    settle();
    configure(5'd1, 12'd0);
    push_text("k=z");
    settle();

    for (int p = 0; p < 5; p++) begin
      for (int i = 0; i < MAX_KEY_BYTES; i++)
        key_text[i] = (p == 2) ? 8'($urandom_range(255)) : alnum_char();
      case (p)
        0: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
          configure(5'd4, 12'd255);
        end
        1: begin
          send_idle_pct = 67;
          recv_stall_pct = 0;
          configure(5'd31, 12'd4095);
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct = 67;
          configure(5'd1, 12'd3);
        end
        3: begin
          send_idle_pct = 11;
          recv_stall_pct = 11;
          configure(5'd2, 12'd0);
        end
        default: begin
          send_idle_pct = 11;
          recv_stall_pct = 11;
          configure(5'd0, 12'd12);
        end
      endcase
      phase_items = 0;
      if (p == 0) begin
        // stall the output while a long value streams in
        hold_start <= 1'b1;
        @(posedge clk);
        hold_start <= 1'b0;
        for (int i = 0; i < key_len_gen; i++) form_body.push_back(key_text[i]);
        form_body.push_back(CH_EQ);
        repeat (40) push_value_char();
        phase_items += form_body.size();
        send_body();
      end
      while (phase_items < PHASE_ITEMS) begin
        build_form_body();
        phase_items += form_body.size();
        send_body();
      end
      settle();
    end

    repeat (20) @(posedge clk);
    $display("covered %0d bodies, %0d body bytes, %0d value words over %0d register settings",
             bodies_seen, bytes_sent, words_checked, settings_used);
    $display("with idle and stall mixes, output hold-off, escapes, key extremes and zero limits");
    if (mismatches == 0) begin
      $display("form_field_extract_decode_top: match");
    end else begin
      $display("form_field_extract_decode_top: mismatch");
    end
    $finish;
  end

endmodule

### form_field_extract_decode_top.f
src/ffd_pkg.sv
src/ffd_front.sv
src/ffd_queue.sv
src/ffd_back.sv
src/form_field_extract_decode_top.sv
src/ffd_checker.sv
bench/form_field_extract_decode_checker.sv
bench/form_field_extract_decode_top_tb.sv
